// ===== hw/rtl/tcw_pkg.sv =====
// Shared types, constants and helpers for the text console writer.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  // fixed port widths
  localparam int COL_PW  = 7;
  localparam int ROW_PW  = 5;
  localparam int LOC_PW  = 11;
  localparam int ADDR_PW = 11;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [0:0] REG_DEF_FG = 1'd0;
  localparam logic [0:0] REG_DEF_BG = 1'd1;

  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_READ    = 3'd2,
    OP_SET_COL = 3'd3,
    OP_SET_ROW = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    SW_NONE   = 2'd0,
    SW_INIT   = 2'd1,
    SW_CLEAR  = 2'd2,
    SW_SCROLL = 2'd3
  } sweep_e;

  typedef struct packed {
    logic   load;
    logic   exec;
    sweep_e sweep;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic scroll;
    logic fill_last;
    logic scroll_last;
  } dp_stat_t;

  typedef logic [COL_W:0] colx_t;
  typedef colx_t [COLUMNS-1:0] tab_tbl_t;

  function automatic tab_tbl_t tab_table();
    tab_tbl_t t;
    for (int i = 0; i < COLUMNS; i++) begin
      t[i] = colx_t'((i / TAB_WIDTH + 1) * TAB_WIDTH);
    end
    return t;
  endfunction

  localparam tab_tbl_t TAB_STOP = tab_table();

  function automatic logic [15:0] make_cell(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
    return {bg, fg, ch};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/text_console_writer_unit.sv =====
// Top level of the text console writer: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// An 80x25 text console with a cursor. Drive a request with start_i while busy_o is low;
// its result appears on the output ports for one cycle with done_o high and must be taken
// then, since the block cannot be stalled. Put, read and set requests go through an execute
// and a done state, and another may start in the cycle done_o is high. Clear screen walks
// the cell memory one write per cycle, and a put that scrolls copies the whole screen up one
// row with one read and one write per cycle. After reset the block clears the cell memory
// with busy_o high; config writes are taken anytime.
module text_console_writer_unit
  import tcw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  output logic                    done_o,
  input  wire logic [2:0]         op_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [3:0]         foreground_i,
  input  wire logic [3:0]         background_i,
  input  wire logic [7:0]         position_value_i,
  input  wire logic [ADDR_PW-1:0] cell_address_i,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [3:0]         cfg_wdata_i,
  output logic [COL_PW-1:0]       cursor_column_o,
  output logic [ROW_PW-1:0]       cursor_row_o,
  output logic [LOC_PW-1:0]       cursor_location_o,
  output logic [7:0]              cell_char_o,
  output logic [7:0]              cell_attr_o,
  output logic                    rejected_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  tcw_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .op_i              (op_i),
    .char_code_i       (char_code_i),
    .foreground_i      (foreground_i),
    .background_i      (background_i),
    .position_value_i  (position_value_i),
    .cell_address_i    (cell_address_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cursor_column_o   (cursor_column_o),
    .cursor_row_o      (cursor_row_o),
    .cursor_location_o (cursor_location_o),
    .cell_char_o       (cell_char_o),
    .cell_attr_o       (cell_attr_o),
    .rejected_o        (rejected_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(cursor_column_o) < COLUMNS) && (32'(cursor_row_o) < ROWS))
    else $error("cursor out of screen");

  a_read_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rejected_o) |-> (cell_char_o == 8'd0) && (cell_attr_o == 8'd0))
    else $error("cell data on a rejected set request");

endmodule
`default_nettype wire

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine for the text console writer.
`timescale 1ns / 1ps
`default_nettype none
module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_CLEAR  = 6'b001000,
    S_SCROLL = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.sweep   = SW_NONE;
    busy_o        = 1'b1;
    done_o        = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep = SW_INIT;
        if (stat_i.fill_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.is_clear)    state_d = S_CLEAR;
        else if (stat_i.scroll) state_d = S_SCROLL;
        else                    state_d = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.sweep = SW_CLEAR;
        if (stat_i.fill_last) state_d = S_DONE;
      end
      S_SCROLL: begin
        cmd_o.sweep = SW_SCROLL;
        if (stat_i.scroll_last) state_d = S_DONE;
      end
      S_DONE: begin
        busy_o = 1'b0;
        done_o = 1'b1;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tcw_dp.sv =====
// Datapath: cell store, cursor, default colours and sweep counter.
`timescale 1ns / 1ps
`default_nettype none
module tcw_dp
  import tcw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  output dp_stat_t                stat_o,
  input  wire logic [2:0]         op_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [3:0]         foreground_i,
  input  wire logic [3:0]         background_i,
  input  wire logic [7:0]         position_value_i,
  input  wire logic [ADDR_PW-1:0] cell_address_i,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [3:0]         cfg_wdata_i,
  output logic [COL_PW-1:0]       cursor_column_o,
  output logic [ROW_PW-1:0]       cursor_row_o,
  output logic [LOC_PW-1:0]       cursor_location_o,
  output logic [7:0]              cell_char_o,
  output logic [7:0]              cell_attr_o,
  output logic                    rejected_o
);

  logic [15:0] mem_q [CELLS];
  logic [15:0] rdata_q;

  op_e                 op_q;
  logic [7:0]          char_q;
  logic [3:0]          fg_q, bg_q;
  logic [7:0]          pos_q;
  logic [ADDR_PW-1:0]  addr_q;

  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [3:0]          def_fg_q, def_bg_q;
  logic                rej_q, rd_ok_q;
  logic [CNT_W-1:0]    cnt_q;

  logic [COL_W:0]      ncol;
  logic [ROW_W:0]      nrow;
  logic                put_we, put_bs, rej, scroll, rd_hit;
  logic [ADDR_W-1:0]   loc;
  logic                we, re;
  logic [ADDR_W-1:0]   wa, ra;
  logic [15:0]         wd;
  logic [CNT_W-1:0]    cnt_m1;

  // item request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      char_q <= char_code_i;
      fg_q   <= foreground_i;
      bg_q   <= background_i;
      pos_q  <= position_value_i;
      addr_q <= cell_address_i;
    end
  end

  assign loc    = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
  assign rd_hit = (32'(addr_q) < CELLS);

  always_comb begin
    ncol   = {1'b0, col_q};
    nrow   = {1'b0, row_q};
    put_we = 1'b0;
    put_bs = 1'b0;
    rej    = 1'b0;
    case (op_q)
      OP_PUT: begin
        case (char_q)
          CH_NL: begin
            ncol = '0;
            nrow = nrow + 1'b1;
          end
          CH_CR: ncol = '0;
          CH_BS: begin
            if (col_q == '0) begin
              if (row_q != '0) begin
                nrow   = nrow - 1'b1;
                ncol   = (COL_W+1)'(COLUMNS - 1);
                put_we = 1'b1;
                put_bs = 1'b1;
              end
            end else begin
              ncol   = ncol - 1'b1;
              put_we = 1'b1;
              put_bs = 1'b1;
            end
          end
          CH_TAB:  ncol = TAB_STOP[col_q];
          default: begin
            put_we = 1'b1;
            ncol   = ncol + 1'b1;
          end
        endcase
        if (32'(ncol) >= COLUMNS) begin
          ncol = '0;
          nrow = nrow + 1'b1;
        end
      end
      OP_CLEAR: begin
        ncol = '0;
        nrow = '0;
      end
      OP_SET_COL: begin
        if (32'(pos_q) < COLUMNS) ncol = (COL_W+1)'(pos_q);
        else                      rej  = 1'b1;
      end
      OP_SET_ROW: begin
        if (32'(pos_q) < ROWS) nrow = (ROW_W+1)'(pos_q);
        else                   rej  = 1'b1;
      end
      default: ;
    endcase
  end

  assign scroll = (32'(nrow) >= ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      rej_q    <= 1'b0;
      rd_ok_q  <= 1'b0;
      cnt_q    <= '0;
      def_fg_q <= 4'd7;
      def_bg_q <= 4'd0;
    end else begin
      if (cmd_i.exec) begin
        col_q   <= scroll ? '0 : ncol[COL_W-1:0];
        row_q   <= scroll ? ROW_W'(ROWS - 1) : nrow[ROW_W-1:0];
        rej_q   <= rej;
        rd_ok_q <= (op_q == OP_READ) && rd_hit;
      end
      if (cmd_i.sweep != SW_NONE) cnt_q <= cnt_q + 1'b1;
      else                        cnt_q <= '0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DEF_FG: def_fg_q <= cfg_wdata_i;
          REG_DEF_BG: def_bg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign cnt_m1 = cnt_q - 1'b1;

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = loc;
    wd = make_cell(char_q, fg_q, bg_q);
    re = 1'b0;
    ra = ADDR_W'(addr_q);
    case (cmd_i.sweep)
      SW_INIT: begin
        we = 1'b1;
        wa = cnt_q[ADDR_W-1:0];
        wd = '0;
      end
      SW_CLEAR: begin
        we = 1'b1;
        wa = cnt_q[ADDR_W-1:0];
        wd = make_cell(CH_SPACE, fg_q, bg_q);
      end
      SW_SCROLL: begin
        we = (cnt_q != '0);
        wa = cnt_m1[ADDR_W-1:0];
        wd = (32'(cnt_m1) < CELLS - COLUMNS) ? rdata_q
                                             : make_cell(CH_SPACE, def_fg_q, def_bg_q);
        re = (32'(cnt_q) < CELLS - COLUMNS);
        ra = ADDR_W'(32'(cnt_q) + COLUMNS);
      end
      SW_NONE: begin
        we = cmd_i.exec && put_we;
        wa = put_bs ? loc - 1'b1 : loc;
        wd = put_bs ? make_cell(CH_SPACE, fg_q, bg_q) : make_cell(char_q, fg_q, bg_q);
        re = cmd_i.exec && (op_q == OP_READ) && rd_hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (re) rdata_q <= mem_q[ra];
  end

  assign stat_o.is_clear    = (op_q == OP_CLEAR);
  assign stat_o.scroll      = scroll;
  assign stat_o.fill_last   = (32'(cnt_q) == CELLS - 1);
  assign stat_o.scroll_last = (32'(cnt_q) == CELLS);

  assign cursor_column_o   = COL_PW'(col_q);
  assign cursor_row_o      = ROW_PW'(row_q);
  assign cursor_location_o = LOC_PW'(loc);
  assign cell_char_o       = rd_ok_q ? rdata_q[7:0] : 8'd0;
  assign cell_attr_o       = rd_ok_q ? rdata_q[15:8] : 8'd0;
  assign rejected_o        = rej_q;

endmodule
`default_nettype wire
